### rtl/bpru_pkg.sv
package bpru_pkg;

   localparam int MAX_WIDTH             = 4096;
   localparam int MAX_HEIGHT            = 4096;
   localparam int PALETTE_DEPTH_DEFAULT = 256;

   localparam logic OP_PALETTE_LOAD = 1'b0;
   localparam logic OP_DATA_BYTE    = 1'b1;

   localparam logic [1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [2:0] DEPTH_1  = 3'd0;
   localparam logic [2:0] DEPTH_4  = 3'd1;
   localparam logic [2:0] DEPTH_8  = 3'd2;
   localparam logic [2:0] DEPTH_24 = 3'd3;
   localparam logic [2:0] DEPTH_32 = 3'd4;

   localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;
   localparam logic [31:0] MASK_AG      = 32'hff00ff00;
   localparam logic [31:0] MASK_RED     = 32'h00ff0000;
   localparam logic [31:0] MASK_BLUE    = 32'h000000ff;

   typedef struct packed {
      logic        operation;
      logic [7:0]  palette_index;
      logic [31:0] palette_word;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic        last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_BIT,
      KIND_NIBBLE,
      KIND_BYTE,
      KIND_DIRECT
   } pixel_kind_type;

   typedef struct packed {
      pixel_kind_type kind;
      logic [7:0]     data_byte;
      logic [31:0]    direct_color;
      logic [3:0]     count;
      logic [11:0]    column;
      logic [11:0]    row;
      logic           last_row_end;
   } job_type;

   function automatic logic [31:0] swap_red_blue(input logic [31:0] c);
      swap_red_blue = (c & MASK_AG) | ((c & MASK_RED) >> 16) | ((c & MASK_BLUE) << 16);
   endfunction

endpackage

### rtl/bmp_pixel_row_unpacker.sv
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  req_data   (req_type)
// response  out        rsp_valid / rsp_ready  rsp_data   (rsp_type)
// csr       in         csr_write_en           csr_index, csr_wdata
//
// one pixel per cycle while the response does not stall, set by the single palette
// read port and the response channel; an 8 bpp or a 24/32 bpp byte stream is taken
// at one byte per cycle without a stall; a 1 bpp byte yields up to 8 pixels, a 4 bpp
// byte up to 2, each through the issue, palette read and response registers
// palette and pixel data are not reset; control registers are, synchronously
// a stalled response holds the pixel stages, and request ready drops once the
// byte in the issue stage cannot finish this cycle
module bmp_pixel_row_unpacker import bpru_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int AddrWidth = $clog2(PALETTE_DEPTH);

   logic                 accept, data_accept, pal_we;
   logic                 job_valid, job_ready;
   job_type              job;
   logic                 rd_en;
   logic [AddrWidth-1:0] rd_addr;
   logic [31:0]          rd_data;

   assign req_ready   = job_ready;
   assign accept      = req_valid && req_ready;
   assign data_accept = accept && (req_data.operation == OP_DATA_BYTE);
   assign pal_we      = accept && (req_data.operation == OP_PALETTE_LOAD)
                        && ({1'b0, req_data.palette_index} < 9'(PALETTE_DEPTH));

   bpru_palette_ram #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (req_data.palette_index[AddrWidth-1:0]),
      .wr_data (swap_red_blue(req_data.palette_word | ALPHA_OPAQUE)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpru_row_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .data_accept  (data_accept),
      .data_byte    (req_data.data_byte),
      .job_valid    (job_valid),
      .job          (job)
   );

   bpru_pixel_pipe #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/bpru_palette_ram.sv
module bpru_palette_ram import bpru_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT,
   localparam int AddrWidth = $clog2(PALETTE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [31:0]          wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [31:0]          rd_data
);

   logic [31:0] store_ff [PALETTE_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bpru_row_tracker.sv
module bpru_row_tracker import bpru_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        data_accept,
   input  logic [7:0]  data_byte,
   output logic        job_valid,
   output job_type     job
);

   logic [2:0]  depth_mode_ff, depth_mode_in;
   logic [12:0] image_width_ff, image_width_in;
   logic [12:0] image_height_ff, image_height_in;
   logic [13:0] row_byte_ff, row_byte_in;
   logic [12:0] column_ff, column_in;
   logic [11:0] file_row_ff, file_row_in;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  gather_count_ff, gather_count_in;

   logic [12:0]    eff_w, eff_h;
   logic [17:0]    w18, row_bits, bits_round;
   logic [14:0]    stride, rb_next;
   logic [12:0]    fr_next, remaining;
   logic           active, gather_full;
   logic [3:0]     n_pix, count;
   pixel_kind_type kind;
   logic [31:0]    direct_color;

   always_comb begin
      if (image_width_ff == 13'd0) begin
         eff_w = 13'd1;
      end else if (image_width_ff > 13'(MAX_WIDTH)) begin
         eff_w = 13'(MAX_WIDTH);
      end else begin
         eff_w = image_width_ff;
      end
      if (image_height_ff == 13'd0) begin
         eff_h = 13'd1;
      end else if (image_height_ff > 13'(MAX_HEIGHT)) begin
         eff_h = 13'(MAX_HEIGHT);
      end else begin
         eff_h = image_height_ff;
      end
   end

   // row stride in bytes, padded to whole 32-bit words
   always_comb begin
      w18 = 18'(eff_w);
      case (depth_mode_ff)
         DEPTH_1: begin
            row_bits = w18;
            kind     = KIND_BIT;
         end
         DEPTH_4: begin
            row_bits = w18 << 2;
            kind     = KIND_NIBBLE;
         end
         DEPTH_24: begin
            row_bits = (w18 << 4) + (w18 << 3);
            kind     = KIND_DIRECT;
         end
         DEPTH_32: begin
            row_bits = w18 << 5;
            kind     = KIND_DIRECT;
         end
         default: begin
            row_bits = w18 << 3;
            kind     = KIND_BYTE;
         end
      endcase
      bits_round = row_bits + 18'd31;
      stride     = {bits_round[17:5], 2'b00};
   end

   always_comb begin
      active    = ({1'b0, file_row_ff} < eff_h) && (column_ff < eff_w);
      remaining = eff_w - column_ff;
      if (depth_mode_ff == DEPTH_24) begin
         gather_full = gather_count_ff >= 2'd2;
         direct_color = {ALPHA_OPAQUE[31:24], gather_ff[7:0], gather_ff[15:8], data_byte};
      end else begin
         gather_full = gather_count_ff == 2'd3;
         direct_color = {data_byte, gather_ff[7:0], gather_ff[15:8], gather_ff[23:16]};
      end
      case (kind)
         KIND_BIT: begin
            n_pix = (remaining >= 13'd8) ? 4'd8 : remaining[3:0];
         end
         KIND_NIBBLE: begin
            n_pix = (remaining >= 13'd2) ? 4'd2 : 4'd1;
         end
         KIND_BYTE: begin
            n_pix = 4'd1;
         end
         default: begin
            n_pix = gather_full ? 4'd1 : 4'd0;
         end
      endcase
      count = active ? n_pix : 4'd0;

      job_valid          = data_accept && (count != 4'd0);
      job.kind           = kind;
      job.data_byte      = data_byte;
      job.direct_color   = direct_color;
      job.count          = count;
      job.column         = column_ff[11:0];
      job.row            = 12'(eff_h - {1'b0, file_row_ff} - 13'd1);
      job.last_row_end   = ({1'b0, file_row_ff} == eff_h - 13'd1)
                           && (column_ff + 13'(count) == eff_w);
   end

   always_comb begin
      depth_mode_in   = depth_mode_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      row_byte_in     = row_byte_ff;
      column_in       = column_ff;
      file_row_in     = file_row_ff;
      gather_in       = gather_ff;
      gather_count_in = gather_count_ff;
      rb_next         = {1'b0, row_byte_ff} + 15'd1;
      fr_next         = {1'b0, file_row_ff} + 13'd1;

      if (csr_write_en) begin
         case (csr_index)
            CSR_DEPTH_MODE: begin
               depth_mode_in   = csr_wdata[2:0];
               gather_in       = '0;
               gather_count_in = '0;
            end
            CSR_IMAGE_WIDTH: begin
               image_width_in  = csr_wdata;
               gather_in       = '0;
               gather_count_in = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata;
               gather_in       = '0;
               gather_count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (data_accept) begin
         if (active) begin
            column_in = column_ff + 13'(n_pix);
            if (kind == KIND_DIRECT) begin
               if (gather_full) begin
                  gather_in       = '0;
                  gather_count_in = '0;
               end else begin
                  case (gather_count_ff)
                     2'd0: begin
                        gather_in = {gather_ff[23:8], data_byte};
                     end
                     2'd1: begin
                        gather_in = {gather_ff[23:16], data_byte, gather_ff[7:0]};
                     end
                     2'd2: begin
                        gather_in = {data_byte, gather_ff[15:0]};
                     end
                     default: begin
                        gather_in = gather_ff;
                     end
                  endcase
                  gather_count_in = gather_count_ff + 2'd1;
               end
            end
         end
         if (rb_next >= stride) begin
            row_byte_in     = '0;
            column_in       = '0;
            gather_in       = '0;
            gather_count_in = '0;
            file_row_in     = (fr_next >= eff_h) ? 12'd0 : fr_next[11:0];
         end else begin
            row_byte_in = rb_next[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff   <= DEPTH_8;
         image_width_ff  <= 13'd1;
         image_height_ff <= 13'd1;
         row_byte_ff     <= '0;
         column_ff       <= '0;
         file_row_ff     <= '0;
         gather_ff       <= '0;
         gather_count_ff <= '0;
      end else begin
         depth_mode_ff   <= depth_mode_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         row_byte_ff     <= row_byte_in;
         column_ff       <= column_in;
         file_row_ff     <= file_row_in;
         gather_ff       <= gather_in;
         gather_count_ff <= gather_count_in;
      end
   end

endmodule

### rtl/bpru_pixel_pipe.sv
module bpru_pixel_pipe import bpru_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT,
   localparam int AddrWidth = $clog2(PALETTE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_ready,
   output logic                 rd_en,
   output logic [AddrWidth-1:0] rd_addr,
   input  logic [31:0]          rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   // issue stage: a pixel of the byte per unstalled cycle
   logic        a_valid_ff, a_valid_in;
   job_type     a_job_ff, a_job_in;
   logic [2:0]  a_step_ff, a_step_in;

   // palette read stage
   logic        b_valid_ff, b_valid_in;
   logic        b_direct_ff, b_direct_in;
   logic        b_oor_ff, b_oor_in;
   logic [31:0] b_color_ff, b_color_in;
   logic [11:0] b_col_ff, b_col_in;
   logic [11:0] b_row_ff, b_row_in;
   logic        b_last_ff, b_last_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        rsp_take, b_move, b_free, issue, final_pix;
   logic [7:0]  pal_idx;

   always_comb begin
      case (a_job_ff.kind)
         KIND_BIT: begin
            pal_idx = {7'd0, a_job_ff.data_byte[3'd7 - a_step_ff]};
         end
         KIND_NIBBLE: begin
            pal_idx = (a_step_ff == 3'd0) ? {4'd0, a_job_ff.data_byte[7:4]}
                                          : {4'd0, a_job_ff.data_byte[3:0]};
         end
         default: begin
            pal_idx = a_job_ff.data_byte;
         end
      endcase
      rsp_take  = !rsp_valid_ff || rsp_ready;
      b_move    = b_valid_ff && rsp_take;
      b_free    = !b_valid_ff || rsp_take;
      issue     = a_valid_ff && b_free;
      final_pix = ({1'b0, a_step_ff} + 4'd1) == a_job_ff.count;
      job_ready = !a_valid_ff || (issue && final_pix);
      rd_en     = issue && (a_job_ff.kind != KIND_DIRECT);
      rd_addr   = pal_idx[AddrWidth-1:0];
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_job_in   = a_job_ff;
      a_step_in  = a_step_ff;
      if (job_valid) begin
         a_valid_in = 1'b1;
         a_job_in   = job;
         a_step_in  = '0;
      end else if (issue && final_pix) begin
         a_valid_in = 1'b0;
      end else if (issue) begin
         a_step_in = a_step_ff + 3'd1;
      end

      b_valid_in  = b_valid_ff;
      b_direct_in = b_direct_ff;
      b_oor_in    = b_oor_ff;
      b_color_in  = b_color_ff;
      b_col_in    = b_col_ff;
      b_row_in    = b_row_ff;
      b_last_in   = b_last_ff;
      if (issue) begin
         b_valid_in  = 1'b1;
         b_direct_in = a_job_ff.kind == KIND_DIRECT;
         b_oor_in    = {1'b0, pal_idx} >= 9'(PALETTE_DEPTH);
         b_color_in  = a_job_ff.direct_color;
         b_col_in    = a_job_ff.column + 12'(a_step_ff);
         b_row_in    = a_job_ff.row;
         b_last_in   = a_job_ff.last_row_end && final_pix;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (b_move) begin
         rsp_valid_in = 1'b1;
         if (b_direct_ff) begin
            rsp_data_in.pixel_color = b_color_ff;
         end else if (b_oor_ff) begin
            rsp_data_in.pixel_color = '0;
         end else begin
            rsp_data_in.pixel_color = rd_data;
         end
         rsp_data_in.pixel_column = b_col_ff;
         rsp_data_in.pixel_row    = b_row_ff;
         rsp_data_in.last_pixel   = b_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_job_ff    <= a_job_in;
      a_step_ff   <= a_step_in;
      b_direct_ff <= b_direct_in;
      b_oor_ff    <= b_oor_in;
      b_color_ff  <= b_color_in;
      b_col_ff    <= b_col_in;
      b_row_ff    <= b_row_in;
      b_last_ff   <= b_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/sv/tb_bmp_pixel_row_unpacker.sv
`timescale 1ns / 1ps

import bpru_pkg::*;

class pixel_scoreboard;
   logic [31:0] palette [256];
   logic [2:0]  depth_sel;
   logic [12:0] width_reg;
   logic [12:0] height_reg;
   int unsigned row_bytes;
   int unsigned column;
   int unsigned file_row;
   logic [23:0] gather;
   int unsigned gather_count;
   rsp_type     expected_pixels[$];
   int          errors;

   function new();
      depth_sel    = DEPTH_8;
      width_reg    = 13'd1;
      height_reg   = 13'd1;
      row_bytes    = 0;
      column       = 0;
      file_row     = 0;
      gather       = '0;
      gather_count = 0;
      errors       = 0;
   endfunction

   function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   function int unsigned bits_per_pixel();
      case (depth_sel)
         DEPTH_1:  return 1;
         DEPTH_4:  return 4;
         DEPTH_24: return 24;
         DEPTH_32: return 32;
         default:  return 8;
      endcase
   endfunction

   function int unsigned row_stride();
      return (eff_width() * bits_per_pixel() + 31) / 32 * 4;
   endfunction

   function void note_csr(logic [1:0] index, logic [12:0] value);
      case (index)
         CSR_DEPTH_MODE:   depth_sel = value[2:0];
         CSR_IMAGE_WIDTH:  width_reg = value;
         CSR_IMAGE_HEIGHT: height_reg = value;
         default:          return;
      endcase
      // a partly gathered pixel is dropped
      gather       = '0;
      gather_count = 0;
   endfunction

   function void push_pixel(logic [31:0] color);
      rsp_type     p;
      int unsigned w;
      int unsigned h;
      w = eff_width();
      h = eff_height();
      p.pixel_color  = color;
      p.pixel_column = 12'(column);
      p.pixel_row    = 12'(h - file_row - 1);
      p.last_pixel   = (column == w - 1) && (file_row == h - 1);
      expected_pixels.push_back(p);
      column++;
   endfunction

   function void note_request(req_type r);
      int unsigned w;
      int unsigned h;
      int unsigned bpp;
      int unsigned need;
      logic [7:0]  b;
      logic [31:0] word;
      logic [31:0] color;
      if (r.operation == OP_PALETTE_LOAD) begin
         word = r.palette_word | ALPHA_OPAQUE;
         palette[r.palette_index] = {word[31:24], word[7:0], word[15:8], word[23:16]};
         return;
      end
      w   = eff_width();
      h   = eff_height();
      bpp = bits_per_pixel();
      b   = r.data_byte;
      if (file_row < h && column < w) begin
         case (bpp)
            1: for (int k = 7; k >= 0 && column < w; k--) push_pixel(palette[b[k]]);
            4: begin
               push_pixel(palette[b[7:4]]);
               if (column < w) push_pixel(palette[b[3:0]]);
            end
            8: push_pixel(palette[b]);
            default: begin
               need = (bpp == 24) ? 2 : 3;
               if (gather_count >= need) begin
                  if (bpp == 24) color = {8'hff, gather[7:0], gather[15:8], b};
                  else color = {b, gather[7:0], gather[15:8], gather[23:16]};
                  push_pixel(color);
                  gather       = '0;
                  gather_count = 0;
               end else begin
                  gather       = gather | (24'(b) << (8 * gather_count));
                  gather_count = (gather_count + 1) % 4;
               end
            end
         endcase
      end
      // padding bytes only advance the row position
      row_bytes++;
      if (row_bytes >= row_stride()) begin
         row_bytes    = 0;
         column       = 0;
         gather       = '0;
         gather_count = 0;
         file_row++;
         if (file_row >= h) file_row = 0;
      end
   endfunction

   task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_response(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("pixel with none expected: %h", got));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_color !== want.pixel_color)
         report_mismatch($sformatf("colour got %h want %h at column %0d row %0d",
            got.pixel_color, want.pixel_color, want.pixel_column, want.pixel_row));
      if (got.pixel_column !== want.pixel_column)
         report_mismatch($sformatf("column got %0d want %0d",
            got.pixel_column, want.pixel_column));
      if (got.pixel_row !== want.pixel_row)
         report_mismatch($sformatf("row got %0d want %0d at column %0d",
            got.pixel_row, want.pixel_row, want.pixel_column));
      if (got.last_pixel !== want.last_pixel)
         report_mismatch($sformatf("last flag got %b want %b at column %0d row %0d",
            got.last_pixel, want.last_pixel, want.pixel_column, want.pixel_row));
   endtask
endclass

module tb_bmp_pixel_row_unpacker import bpru_pkg::*;;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 220;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_TAIL     = 32;
   localparam int WATCHDOG_NS   = 4_000_000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   pixel_scoreboard sb;
   int unsigned     burst_left = 4;
   int unsigned     items_sent = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   bmp_pixel_row_unpacker dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (csr_write_en) sb.note_csr(csr_index, csr_wdata);
      end
   end

   task automatic offer_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 16);
      end else begin
         burst_left--;
      end
   endtask

   task automatic load_palette(input logic [7:0] index, input logic [31:0] word);
      req_type r;
      r.operation     = OP_PALETTE_LOAD;
      r.palette_index = index;
      r.palette_word  = word;
      r.data_byte     = 8'($urandom);
      offer_request(r);
   endtask

   task automatic send_byte(input logic [7:0] value);
      req_type r;
      r.operation     = OP_DATA_BYTE;
      r.palette_index = 8'($urandom);
      r.palette_word  = $urandom;
      r.data_byte     = value;
      offer_request(r);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [12:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [12:0] pick_size(input int unsigned ceiling,
                                             input int unsigned common_max);
      case ($urandom_range(0, 15))
         0:       return 13'd0;
         1:       return 13'(ceiling);
         2:       return 13'($urandom_range(ceiling + 1, 8191));
         3:       return 13'($urandom_range(common_max + 1, 300));
         default: return 13'($urandom_range(1, common_max));
      endcase
   endfunction

   initial begin : receiver
      int unsigned mode;
      int unsigned span;
      bit          held;
      held = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!held && items_sent >= HOLD_AT) begin
            // long stall so the pipeline backs up into the request side
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 60);
            repeat (span) begin
               if (!held && items_sent >= HOLD_AT) break;
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= 1'($urandom_range(0, 1));
               endcase
               @(negedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #WATCHDOG_NS;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_items;
      int unsigned image_bytes;
      int unsigned random_items;
      sb = new();
      random_items = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every entry written before any pixel can look one up
      for (int i = 0; i < 256; i++) load_palette(8'(i), $urandom);

      // reset settings: 8 bpp, one pixel, one row
      load_palette(8'd0, 32'h0000_0000);
      load_palette(8'd255, 32'hffff_ffff);
      send_byte(8'hff);
      repeat (3) send_byte(8'h00);
      drain();

      // 1 bpp with a partial last byte
      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_1));
      write_csr(CSR_IMAGE_WIDTH, 13'd9);
      send_byte(8'ha5);
      send_byte(8'h80);
      repeat (2) send_byte(8'h00);
      drain();

      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_4));
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      send_byte(8'h0f);
      send_byte(8'hf0);
      repeat (2) send_byte(8'h00);
      drain();

      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_24));
      write_csr(CSR_IMAGE_WIDTH, 13'd1);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h00);
      drain();

      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_32));
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h7f);
      drain();

      // partial gather survives an unused index but not a real write
      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_24));
      send_byte(8'h55);
      drain();
      write_csr(CSR_UNUSED, 13'h1fff);
      write_csr(CSR_DEPTH_MODE, 13'(DEPTH_24));
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      drain();

      // unknown depth, zero width and oversized height
      write_csr(CSR_DEPTH_MODE, 13'd7);
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      write_csr(CSR_IMAGE_HEIGHT, 13'h1fff);

      while (random_items < RANDOM_ITEMS) begin
         image_bytes = sb.row_stride() * sb.eff_height();
         if (image_bytes <= 128 && $urandom_range(0, 3) != 0) begin
            phase_items = image_bytes * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) phase_items += $urandom_range(1, 5);
         end else begin
            phase_items = $urandom_range(4, 48);
         end
         // keep offering well past the point where the long stall starts
         if (items_sent < HOLD_AT && items_sent + phase_items >= HOLD_AT
             && items_sent + phase_items < HOLD_AT + HOLD_TAIL)
            phase_items = HOLD_AT + HOLD_TAIL - items_sent;
         repeat (phase_items) begin
            if ($urandom_range(0, 9) == 0) load_palette(8'($urandom), $urandom);
            else send_byte(8'($urandom));
         end
         random_items += phase_items;
         drain();
         if ($urandom_range(0, 3) != 0)
            write_csr(CSR_DEPTH_MODE, 13'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                                      : $urandom_range(0, 4)));
         if ($urandom_range(0, 2) != 0)
            write_csr(CSR_IMAGE_WIDTH, pick_size(MAX_WIDTH, 24));
         if ($urandom_range(0, 2) != 0)
            write_csr(CSR_IMAGE_HEIGHT, pick_size(MAX_HEIGHT, 3));
         if ($urandom_range(0, 15) == 0)
            write_csr(CSR_UNUSED, 13'($urandom));
      end

      drain();
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### sim.f
rtl/bpru_pkg.sv
rtl/bpru_palette_ram.sv
rtl/bpru_row_tracker.sv
rtl/bpru_pixel_pipe.sv
rtl/bmp_pixel_row_unpacker.sv
tb/sv/tb_bmp_pixel_row_unpacker.sv
